[src/alm_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alm_pkg: shared types and constants
// operation codes, status codes and default sizes of the list manager
// ----------------------------------------------------------------------------
package alm_pkg;

  localparam int DefCapacity  = 32;
  localparam int DefDataWidth = 32;
  localparam int IdxWidth     = 6;

  typedef enum logic [2:0] {
    OP_ADD_FRONT  = 3'd0,
    OP_ADD_REAR   = 3'd1,
    OP_REM_FRONT  = 3'd2,
    OP_REM_REAR   = 3'd3,
    OP_REM_CUR    = 3'd4,
    OP_CLEAR      = 3'd5,
    OP_READ_CUR   = 3'd6,
    OP_DUMP       = 3'd7
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

endpackage

[src/alm_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alm_in_if / alm_out_if: valid/ready channels
// operation words in, result words out
// ----------------------------------------------------------------------------
interface alm_in_if #(parameter int DATA_WIDTH = 32);
  logic                  valid;
  logic                  ready;
  logic [2:0]            operation;
  logic [DATA_WIDTH-1:0] item_data;
  modport source (output valid, operation, item_data, input ready);
  modport sink (input valid, operation, item_data, output ready);
endinterface

interface alm_out_if #(parameter int DATA_WIDTH = 32);
  logic                  valid;
  logic                  ready;
  logic [1:0]            status;
  logic [DATA_WIDTH-1:0] out_data;
  logic                  last;
  modport source (output valid, status, out_data, last, input ready);
  modport sink (input valid, status, out_data, last, output ready);
endinterface

[src/alm_store.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alm_store: node store
// payload and link memories, one write and one registered read each
// ----------------------------------------------------------------------------
module alm_store import alm_pkg::*; #(
  parameter int CAPACITY   = DefCapacity,
  parameter int DATA_WIDTH = DefDataWidth
) (
  input  logic                  clk,
  input  logic                  pay_we,
  input  logic [IdxWidth-1:0]   pay_waddr,
  input  logic [DATA_WIDTH-1:0] pay_wdata,
  input  logic [IdxWidth-1:0]   pay_raddr,
  output logic [DATA_WIDTH-1:0] pay_rdata,
  input  logic                  nxt_we,
  input  logic [IdxWidth-1:0]   nxt_waddr,
  input  logic [IdxWidth-1:0]   nxt_wdata,
  input  logic [IdxWidth-1:0]   nxt_raddr,
  output logic [IdxWidth-1:0]   nxt_rdata,
  input  logic                  fre_we,
  input  logic [IdxWidth-1:0]   fre_waddr,
  input  logic [IdxWidth-1:0]   fre_wdata,
  input  logic [IdxWidth-1:0]   fre_raddr,
  output logic [IdxWidth-1:0]   fre_rdata
);
  localparam int Depth = 1 << IdxWidth;

  logic [DATA_WIDTH-1:0] pay_mem [Depth];
  logic [IdxWidth-1:0]   nxt_mem [Depth];
  logic [IdxWidth-1:0]   fre_mem [Depth];

  always_ff @(posedge clk) begin
    if (pay_we) pay_mem[pay_waddr] <= pay_wdata;
    pay_rdata <= pay_mem[pay_raddr];
  end

  // link memory reads the new value when written at the same address
  always_ff @(posedge clk) begin
    if (nxt_we) nxt_mem[nxt_waddr] <= nxt_wdata;
    if (nxt_we && nxt_waddr == nxt_raddr) nxt_rdata <= nxt_wdata;
    else nxt_rdata <= nxt_mem[nxt_raddr];
  end

  always_ff @(posedge clk) begin
    if (fre_we) fre_mem[fre_waddr] <= fre_wdata;
    fre_rdata <= fre_mem[fre_raddr];
  end
endmodule

[src/array_linked_list_manager.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// array_linked_list_manager: linked list in a node store with a free list
// sequencer walking the links one memory read per step
// ----------------------------------------------------------------------------
// usage
//   in  (alm_in_if sink): one word = operation + item_data
//   out (alm_out_if source): result words status/out_data/last
//   one operation at a time; in.ready is high only when idle and the output
//   register is empty. every operation gives one result word with last set,
//   except a dump of a non-empty list, one word per node, last on the tail.
//   rear add, rear removal, current removal and clear walk the chain in
//   three steps per link (issue, registered link memory read, evaluate);
//   dump walks the chain the same way and emits one word per node, holding
//   its emit step while the output register is full and out.ready is low.
//   the next word is taken only after the last result word has been taken.
//   a stall on out holds the result register and the walk waits on it.
//   reset (rst, synchronous) empties the list, the free list and the
//   high-water counter; node memories need no clearing.
// ----------------------------------------------------------------------------
module array_linked_list_manager import alm_pkg::*; #(
  parameter int CAPACITY   = DefCapacity,
  parameter int DATA_WIDTH = DefDataWidth
) (
  input  logic clk,
  input  logic rst,
  alm_in_if.sink    in,
  alm_out_if.source out
);
  localparam int IW = IdxWidth;
  localparam logic [IW-1:0] Cap = IW'(CAPACITY);
  localparam logic [IW-1:0] Zero = '0;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_RD    = 7'b0000010, // issue read of link at addr
    S_WAIT  = 7'b0000100, // read data arrives
    S_STEP  = 7'b0001000, // evaluate one walk step
    S_DONE  = 7'b0010000, // push final result word
    S_FREE  = 7'b0100000, // free list pop read result
    S_DUMP  = 7'b1000000  // emit a dump word
  } state_t;

  state_t state;
  op_t    op;
  logic [DATA_WIDTH-1:0] data_r;
  logic [IW-1:0] head, cur, fhead, hwater;
  logic [IW-1:0] p, pre;          // walk pointers
  logic [IW:0]   steps;
  logic [1:0]    st_r;

  // memory ports
  logic pay_we, nxt_we, fre_we;
  logic [IW-1:0] pay_waddr, nxt_waddr, nxt_wdata, fre_waddr, fre_wdata;
  logic [IW-1:0] pay_raddr, nxt_raddr, fre_raddr;
  logic [DATA_WIDTH-1:0] pay_rdata;
  logic [IW-1:0] nxt_rdata, fre_rdata;

  // output register
  logic ov;
  logic [1:0] ost;
  logic [DATA_WIDTH-1:0] odata;
  logic olast;

  assign out.valid    = ov;
  assign out.status   = ost;
  assign out.out_data = odata;
  assign out.last     = olast;
  assign in.ready     = (state == S_IDLE) && !ov;

  logic oslot;  // output slot free this cycle
  assign oslot = !ov || out.ready;

  alm_store #(.CAPACITY(CAPACITY), .DATA_WIDTH(DATA_WIDTH)) u_store (
    .clk, .pay_we, .pay_waddr, .pay_wdata(data_r), .pay_raddr, .pay_rdata,
    .nxt_we, .nxt_waddr, .nxt_wdata, .nxt_raddr, .nxt_rdata,
    .fre_we, .fre_waddr, .fre_wdata, .fre_raddr, .fre_rdata
  );

  // read addresses follow the walk pointer; free link follows free head
  assign nxt_raddr = p;
  assign pay_raddr = p;
  assign fre_raddr = fhead;

  logic full;
  assign full = (fhead == Zero) && (hwater >= Cap);

  // write controls, driven by the sequencer below
  logic [IW-1:0] new_slot;
  assign new_slot = (fhead != Zero) ? fhead : hwater + IW'(1);

  always_ff @(posedge clk) begin
    pay_we <= 1'b0;
    nxt_we <= 1'b0;
    fre_we <= 1'b0;
    if (rst) begin
      state <= S_IDLE;
      head <= '0; cur <= '0; fhead <= '0; hwater <= '0;
      ov <= 1'b0;
    end else begin
      if (out.ready) ov <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (in.valid && in.ready) begin
            op <= op_t'(in.operation);
            data_r <= in.item_data;
            st_r <= ST_OK;
            steps <= '0;
            unique case (op_t'(in.operation))
              OP_ADD_FRONT, OP_ADD_REAR: begin
                if (full) begin
                  st_r <= ST_FULL; state <= S_DONE;
                end else if (in.operation == OP_ADD_REAR && head != Zero) begin
                  p <= head; state <= S_RD;
                end else begin
                  op <= OP_ADD_FRONT; state <= S_FREE;
                end
              end
              OP_REM_FRONT, OP_REM_REAR, OP_CLEAR, OP_DUMP: begin
                if (head == Zero) begin
                  st_r <= (in.operation == OP_CLEAR) ? ST_OK : ST_EMPTY;
                  state <= S_DONE;
                end else begin
                  p <= head; pre <= Zero; state <= S_RD;
                end
              end
              OP_REM_CUR: begin
                if (head == Zero || cur == Zero) begin
                  st_r <= ST_EMPTY; state <= S_DONE;
                end else begin
                  p <= head; pre <= Zero; state <= S_RD;
                end
              end
              OP_READ_CUR: begin
                if (cur == Zero) begin
                  st_r <= ST_EMPTY; state <= S_DONE;
                end else begin
                  p <= cur; state <= S_RD;
                end
              end
              default: state <= S_DONE;
            endcase
          end
        end
        S_RD: state <= S_WAIT;
        S_WAIT: state <= (op == OP_DUMP) ? S_DUMP : S_STEP;
        S_FREE: begin
          // new_slot taken; fre_rdata holds the link of the free head
          pay_we <= 1'b1; pay_waddr <= new_slot;
          nxt_we <= 1'b1; nxt_waddr <= new_slot;
          if (fhead != Zero) fhead <= fre_rdata;
          else hwater <= new_slot;
          cur <= new_slot;
          if (op == OP_ADD_FRONT) begin
            nxt_wdata <= head; head <= new_slot; state <= S_DONE;
          end else begin
            nxt_wdata <= Zero; p <= new_slot; state <= S_STEP;
          end
        end
        S_STEP: begin
          unique case (op)
            OP_ADD_REAR: begin
              if (p == cur && steps == '1) begin
                // old tail in pre now links to the new node
                nxt_we <= 1'b1; nxt_waddr <= pre; nxt_wdata <= p;
                state <= S_DONE;
              end else if (nxt_rdata == Zero || steps == (IW+1)'(CAPACITY)) begin
                // p is the tail: link new node after it
                pre <= p; steps <= '1; state <= S_FREE;
              end else begin
                p <= nxt_rdata; steps <= steps + 1'b1; state <= S_RD;
              end
            end
            OP_REM_FRONT: begin
              fre_we <= 1'b1; fre_waddr <= p; fre_wdata <= fhead;
              fhead <= p; head <= nxt_rdata; cur <= nxt_rdata;
              state <= S_DONE;
            end
            OP_CLEAR: begin
              fre_we <= 1'b1; fre_waddr <= p; fre_wdata <= fhead;
              fhead <= p;
              if (nxt_rdata == Zero || steps == (IW+1)'(CAPACITY - 1)) begin
                head <= Zero; cur <= Zero; state <= S_DONE;
              end else begin
                p <= nxt_rdata; steps <= steps + 1'b1; state <= S_RD;
              end
            end
            OP_REM_REAR: begin
              if (pre == Zero && nxt_rdata == Zero) begin
                op <= OP_REM_FRONT; state <= S_STEP;
              end else if (pre != Zero && (nxt_rdata == Zero ||
                           steps == (IW+1)'(CAPACITY))) begin
                nxt_we <= 1'b1; nxt_waddr <= pre; nxt_wdata <= Zero;
                fre_we <= 1'b1; fre_waddr <= p; fre_wdata <= fhead;
                fhead <= p; cur <= pre; state <= S_DONE;
              end else begin
                if (pre != Zero) steps <= steps + 1'b1;
                pre <= p; p <= nxt_rdata; state <= S_RD;
              end
            end
            OP_REM_CUR: begin
              if (p == cur && pre == Zero) begin
                op <= OP_REM_FRONT; state <= S_STEP;
              end else if (p == cur) begin
                // p is current, pre its predecessor
                nxt_we <= 1'b1; nxt_waddr <= pre; nxt_wdata <= nxt_rdata;
                fre_we <= 1'b1; fre_waddr <= p; fre_wdata <= fhead;
                fhead <= p; cur <= pre; state <= S_DONE;
              end else if (p == Zero || (pre != Zero &&
                           steps == (IW+1)'(CAPACITY))) begin
                st_r <= ST_EMPTY; state <= S_DONE;
              end else begin
                if (pre != Zero) steps <= steps + 1'b1;
                pre <= p; p <= nxt_rdata; state <= S_RD;
              end
            end
            OP_READ_CUR: begin
              if (oslot) begin
                ov <= 1'b1; ost <= ST_OK; odata <= pay_rdata; olast <= 1'b1;
                state <= S_IDLE;
              end
            end
            default: state <= S_DONE;
          endcase
        end
        S_DUMP: begin
          if (oslot) begin
            ov <= 1'b1; ost <= ST_OK; odata <= pay_rdata;
            steps <= steps + 1'b1;
            if (nxt_rdata == Zero || steps == (IW+1)'(CAPACITY - 1)) begin
              olast <= 1'b1; state <= S_IDLE;
            end else begin
              olast <= 1'b0; p <= nxt_rdata; state <= S_RD;
            end
          end
        end
        S_DONE: begin
          if (oslot) begin
            ov <= 1'b1; ost <= st_r; odata <= '0; olast <= 1'b1;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

[tb/alm_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alm_checker: list manager scoreboard
// watches both channels, keeps its own copy of the list and compares words
// ----------------------------------------------------------------------------
module alm_checker import alm_pkg::*; #(
  parameter int CAPACITY = DefCapacity
) (
  input  logic clk,
  input  logic rst,
  alm_in_if    in_ch,
  alm_out_if   out_ch,
  output int   fails,
  output int   pending,
  output int   full_seen
);

  typedef struct packed {
    status_t     status;
    logic [31:0] data;
    logic        last;
  } result_word_t;

  logic [31:0] payload [0:63];
  logic [5:0]  next_lnk [0:63];
  logic [5:0]  free_lnk [0:63];
  logic [5:0]  head, cur, free_head, high_water;
  result_word_t result_q [$];

  task automatic push_result(status_t st, logic [31:0] d, logic l);
    result_word_t w;
    w.status = st;
    w.data   = d;
    w.last   = l;
    result_q.push_back(w);
    if (st == ST_FULL) full_seen++;
  endtask

  task automatic take_slot(output logic [5:0] s);
    s = 0;
    if (free_head != 0) begin
      s = free_head;
      free_head = free_lnk[s];
    end else if (high_water < CAPACITY) begin
      high_water = high_water + 6'd1;
      s = high_water;
    end
  endtask

  task automatic give_slot(input logic [5:0] s);
    free_lnk[s] = free_head;
    free_head = s;
  endtask

  task automatic drop_front();
    logic [5:0] h, nx;
    h = head;
    nx = next_lnk[h];
    give_slot(h);
    head = nx;
    cur = nx;
  endtask

  task automatic apply_op(op_t op, logic [31:0] d);
    logic [5:0] p, pre, s;
    int n;
    case (op)
      OP_ADD_FRONT, OP_ADD_REAR: begin
        p = head;
        if (op == OP_ADD_REAR && head != 0) begin
          for (int k = 0; k < CAPACITY && next_lnk[p] != 0; k++) p = next_lnk[p];
        end
        take_slot(s);
        if (s == 0) begin
          push_result(ST_FULL, 0, 1);
        end else begin
          payload[s] = d;
          if (op == OP_ADD_REAR && head != 0) begin
            next_lnk[s] = 0;
            next_lnk[p] = s;
          end else begin
            next_lnk[s] = head;
            head = s;
          end
          cur = s;
          push_result(ST_OK, 0, 1);
        end
      end
      OP_REM_FRONT: begin
        if (head == 0) push_result(ST_EMPTY, 0, 1);
        else begin
          drop_front();
          push_result(ST_OK, 0, 1);
        end
      end
      OP_REM_REAR: begin
        if (head == 0) push_result(ST_EMPTY, 0, 1);
        else if (next_lnk[head] == 0) begin
          drop_front();
          push_result(ST_OK, 0, 1);
        end else begin
          pre = head;
          p = next_lnk[pre];
          for (int k = 0; k < CAPACITY && next_lnk[p] != 0; k++) begin
            pre = p;
            p = next_lnk[p];
          end
          next_lnk[pre] = 0;
          give_slot(p);
          cur = pre;
          push_result(ST_OK, 0, 1);
        end
      end
      OP_REM_CUR: begin
        if (head == 0 || cur == 0) push_result(ST_EMPTY, 0, 1);
        else if (cur == head) begin
          drop_front();
          push_result(ST_OK, 0, 1);
        end else begin
          pre = head;
          for (int k = 0; k < CAPACITY && pre != 0 && next_lnk[pre] != cur; k++)
            pre = next_lnk[pre];
          if (pre == 0 || next_lnk[pre] != cur) push_result(ST_EMPTY, 0, 1);
          else begin
            next_lnk[pre] = next_lnk[cur];
            give_slot(cur);
            cur = pre;
            push_result(ST_OK, 0, 1);
          end
        end
      end
      OP_CLEAR: begin
        for (int k = 0; k < CAPACITY && head != 0; k++) drop_front();
        head = 0;
        cur = 0;
        push_result(ST_OK, 0, 1);
      end
      OP_READ_CUR: begin
        if (cur == 0) push_result(ST_EMPTY, 0, 1);
        else push_result(ST_OK, payload[cur], 1);
      end
      default: begin
        if (head == 0) push_result(ST_EMPTY, 0, 1);
        else begin
          n = 0;
          p = head;
          while (p != 0 && n < CAPACITY) begin
            n++;
            s = next_lnk[p];
            push_result(ST_OK, payload[p], (s == 0 || n == CAPACITY));
            p = s;
          end
        end
      end
    endcase
  endtask

  always @(posedge clk) begin
    result_word_t w;
    if (rst) begin
      head = 0;
      cur = 0;
      free_head = 0;
      high_water = 0;
      result_q.delete();
      fails = 0;
      full_seen = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (result_q.size() == 0) begin
          $error("unexpected result word: status %0d out_data %h last %0d",
                 out_ch.status, out_ch.out_data, out_ch.last);
          fails++;
        end else begin
          w = result_q.pop_front();
          if (out_ch.status !== w.status) begin
            $error("status mismatch: expected %0d, actual %0d", w.status, out_ch.status);
            fails++;
          end
          if (out_ch.out_data !== w.data) begin
            $error("out_data mismatch: expected %h, actual %h", w.data, out_ch.out_data);
            fails++;
          end
          if (out_ch.last !== w.last) begin
            $error("last mismatch: expected %0d, actual %0d", w.last, out_ch.last);
            fails++;
          end
        end
      end
      if (in_ch.valid && in_ch.ready) apply_op(op_t'(in_ch.operation), in_ch.item_data);
    end
    pending = result_q.size();
  end

endmodule

[tb/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: list manager testbench
// directed list operations, then add-heavy, mixed and drain-heavy random
// phases with random gaps on both channels, checked by alm_checker
// ----------------------------------------------------------------------------
module tb;
  import alm_pkg::*;

  localparam int CAP      = 32;
  localparam int LIMIT    = 2000000;
  localparam int NRANDOM  = 200;

  logic clk = 0;
  logic rst = 1;

  alm_in_if  #(.DATA_WIDTH(32)) in_ch ();
  alm_out_if #(.DATA_WIDTH(32)) out_ch ();

  int fails, pending, full_seen;
  int cycles = 0;
  int words_sent = 0;
  int words_seen = 0;
  bit gaps_on = 1;      // sender idling enabled
  bit rx_gaps_on = 1;   // receiver stalls enabled

  array_linked_list_manager #(.CAPACITY(CAP), .DATA_WIDTH(32)) uut (
    .clk(clk), .rst(rst), .in(in_ch.sink), .out(out_ch.source)
  );

  alm_checker #(.CAPACITY(CAP)) chk (
    .clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch),
    .fails(fails), .pending(pending), .full_seen(full_seen)
  );

  always #6 clk = ~clk;

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("array_linked_list_manager verification failed");
      $finish;
    end
  end

  // send one operation word; valid stays high when the next word follows at once
  task automatic send_word(op_t op, logic [31:0] d);
    int gap;
    gap = gaps_on ? $urandom_range(0, 18) : 0;
    if (gap > 0) begin
      in_ch.valid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid     <= 1;
    in_ch.operation <= op;
    in_ch.item_data <= d;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    words_sent++;
  endtask

  // random op mix: weights for adds, removes, other
  function automatic op_t pick_op(int add_w, int rem_w);
    int r;
    r = $urandom_range(0, 99);
    if (r < add_w) return ($urandom_range(0, 1)) ? OP_ADD_REAR : OP_ADD_FRONT;
    if (r < add_w + rem_w) begin
      case ($urandom_range(0, 2))
        0: return OP_REM_FRONT;
        1: return OP_REM_REAR;
        default: return OP_REM_CUR;
      endcase
    end
    case ($urandom_range(0, 5))
      0: return OP_CLEAR;
      1, 2: return OP_READ_CUR;
      default: return OP_DUMP;
    endcase
  endfunction

  // receiver: random stalls and one long hold-off, which also holds back the sender
  initial begin
    int stall;
    out_ch.ready = 0;
    @(negedge rst);
    forever begin
      if (words_seen == 60) begin
        out_ch.ready <= 0;
        repeat (400) @(posedge clk);
      end
      stall = rx_gaps_on ? $urandom_range(0, 18) : 0;
      if (stall > 0) begin
        out_ch.ready <= 0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1;
      @(posedge clk);
      while (!out_ch.valid) @(posedge clk);
      words_seen++;
    end
  end

  initial begin
    op_t op;
    in_ch.valid = 0;
    in_ch.operation = OP_READ_CUR;
    in_ch.item_data = 0;
    repeat (3) @(posedge clk);
    rst <= 0;

    // directed: empty-list cases, extremes of data, every operation
    send_word(OP_REM_FRONT, 0);
    send_word(OP_REM_REAR, 0);
    send_word(OP_REM_CUR, 0);
    send_word(OP_READ_CUR, 0);
    send_word(OP_DUMP, 0);
    send_word(OP_CLEAR, 0);
    send_word(OP_ADD_REAR, 32'hFFFF_FFFF);   // rear add on empty list
    send_word(OP_REM_REAR, 0);               // one-node rear removal
    send_word(OP_ADD_FRONT, 32'h0000_0000);
    send_word(OP_ADD_FRONT, 32'hFFFF_FFFF);
    send_word(OP_ADD_REAR, 32'hA5A5_5A5A);
    send_word(OP_READ_CUR, 0);
    send_word(OP_DUMP, 0);
    send_word(OP_REM_CUR, 0);                // current is not head
    send_word(OP_READ_CUR, 0);
    send_word(OP_REM_REAR, 0);
    send_word(OP_ADD_FRONT, 32'h5A5A_A5A5);
    send_word(OP_REM_CUR, 0);                // current equals head
    send_word(OP_REM_FRONT, 0);
    send_word(OP_DUMP, 0);
    send_word(OP_ADD_REAR, 32'h1234_5678);
    send_word(OP_CLEAR, 0);                  // clear a non-empty list
    send_word(OP_DUMP, 0);

    // pause until every result of the directed part has come back
    in_ch.valid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);

    for (int i = 0; i < NRANDOM; i++) begin
      if (i % 40 == 20) gaps_on = 0;
      if (i % 40 == 0) gaps_on = 1;
      rx_gaps_on = (i % 50) < 35;
      if (i < 90) op = pick_op(80, 8);          // fill up and hit a full store
      else if (i < 150) op = pick_op(45, 35);  // mixed
      else op = pick_op(20, 60);               // drain
      send_word(op, $urandom());
    end
    in_ch.valid <= 0;

    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (100) @(posedge clk);

    $display("sent %0d operation words, %0d result words, %0d full-store results",
             words_sent, words_seen, full_seen);
    if (fails == 0) begin
      $display("array_linked_list_manager verification clean");
    end else begin
      $display("array_linked_list_manager verification failed");
    end
    $finish;
  end

endmodule
